// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pecpw_pkg.sv =====
// Package with the constants and codes of the page-write EEPROM block.
package pecpw_pkg;

  localparam int ADDR_W     = 19;
  localparam int DATA_W     = 8;
  localparam int ID_W       = 16;
  localparam int DELAY_W    = 16;
  localparam int PAGE_BYTES = 128;
  localparam int PAGE_OFS_W = 7;
  localparam int PAGE_NUM_W = ADDR_W - PAGE_OFS_W;
  localparam int ENTRY_W    = ADDR_W + DATA_W;

  typedef logic [1:0]        action_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] byte_t;
  typedef logic [2:0]        seq_t;

  localparam action_t ACT_READ  = 2'd0;
  localparam action_t ACT_WRITE = 2'd1;
  localparam action_t ACT_TICK  = 2'd2;

  localparam addr_t UNLOCK_ADDR1 = 19'h05555;
  localparam addr_t UNLOCK_ADDR2 = 19'h02AAA;
  localparam byte_t UNLOCK_BYTE1 = 8'hAA;
  localparam byte_t UNLOCK_BYTE2 = 8'h55;

  localparam byte_t CMD_PAGE_WRITE = 8'hA0;
  localparam byte_t CMD_SECOND_SEQ = 8'h80;
  localparam byte_t CMD_ID_MODE    = 8'h90;
  localparam byte_t CMD_NORMAL     = 8'hF0;
  localparam byte_t CMD_PROT_OFF   = 8'h20;
  localparam byte_t CMD_ERASE      = 8'h10;
  localparam byte_t CMD_ID_MODE2   = 8'h60;

  localparam byte_t ERASED_BYTE = 8'hFF;

  localparam seq_t SQ_START    = 3'd0;
  localparam seq_t SQ_GOT_AA   = 3'd1;
  localparam seq_t SQ_COMMAND  = 3'd2;
  localparam seq_t SQ_PAGE     = 3'd3;
  localparam seq_t SQ_START2   = 3'd4;
  localparam seq_t SQ_GOT_AA2  = 3'd5;
  localparam seq_t SQ_COMMAND2 = 3'd6;

  localparam logic CFG_PRODUCT_ID  = 1'b0;
  localparam logic CFG_WRITE_DELAY = 1'b1;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd1000;

endpackage

// ===== rtl/pecpw_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module pecpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/parallel_eeprom_command_page_write.sv =====
// Top level of the byte-wide EEPROM with unlock sequences and page write.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+--------------------------------
//   command   | start in, busy out         | action, address, data
//   result    | done out (one-cycle pulse) | read_data, write_busy
//   config    | cfg_valid in, cfg_ready out| cfg_index, cfg_data
//
// A read, a byte write or a tick is accepted at an edge with start high and
// busy low, and its result shows with done in the following cycle. Reads of
// storage use the registered read port of the storage memory, so their data
// arrives exactly in that result cycle. A tick that ends the countdown commits
// a page: the page is first rewritten with FF through the single storage write
// port, then the pending buffer is walked in order, laying the buffered bytes
// on top. A chip erase walks the storage write port over every address of the
// storage. Busy is high for those walks; the result of the item that caused
// them is shown at once.
// Reset is synchronous and clears the control state only; storage and the
// pending buffer keep whatever they hold, and no clearing pass is run.
// The result side has no stall, and configuration is always ready.
module parallel_eeprom_command_page_write #(
  parameter int MEMORY_BYTES   = 131072,
  parameter int BUFFER_ENTRIES = 128
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  pecpw_pkg::action_t       action,
  input  pecpw_pkg::addr_t         address,
  input  pecpw_pkg::byte_t         data,
  output logic                     done,
  output pecpw_pkg::byte_t         read_data,
  output logic                     write_busy,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [15:0]              cfg_data
);

  import pecpw_pkg::*;

  // Storage index width, pending buffer index width and fill-count width.
  localparam int AW = (MEMORY_BYTES > 1) ? $clog2(MEMORY_BYTES) : 1;
  localparam int BW = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
  localparam int CW = $clog2(BUFFER_ENTRIES + 1);
  localparam logic [ADDR_W:0]  MEM_LIMIT  = (ADDR_W + 1)'(MEMORY_BYTES);
  localparam logic [AW-1:0]    ERASE_LAST = AW'(MEMORY_BYTES - 1);
  localparam logic [CW-1:0]    BUF_FULL   = CW'(BUFFER_ENTRIES);

  // Controller states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ERASE = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0]            state;

  // Configuration registers.
  logic [ID_W-1:0]       product_id;
  logic [DELAY_W-1:0]    write_delay_ticks;

  // Protocol state.
  seq_t                  seq_state;
  logic                  id_mode;
  logic [DELAY_W-1:0]    countdown;
  logic [CW-1:0]         pending_count;
  addr_t                 last_write_address;

  // Walk counters.
  logic [AW-1:0]         erase_idx;
  logic [PAGE_OFS_W-1:0] fill_idx;
  logic [CW-1:0]         scan_idx;
  logic                  scan_vld;

  // Result registers.
  byte_t                 rd_reg;
  logic                  rd_from_ram;

  // Memory ports.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  byte_t                 mem_wdata;
  logic                  mem_re;
  byte_t                 mem_q;
  logic                  buf_we;
  logic                  buf_re;
  logic [ENTRY_W-1:0]    buf_q;

  logic                  accept;
  logic [PAGE_NUM_W-1:0] commit_page;
  addr_t                 fill_addr;
  addr_t                 entry_addr;
  logic                  scan_issue;
  logic                  entry_hit;
  logic [DELAY_W-1:0]    tick_count;

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign read_data  = rd_from_ram ? mem_q : rd_reg;

  assign commit_page = last_write_address[ADDR_W-1:PAGE_OFS_W];
  assign fill_addr   = {commit_page, fill_idx};
  assign entry_addr  = buf_q[ENTRY_W-1:DATA_W];
  assign scan_issue  = (state == ST_SCAN) && (scan_idx < pending_count);
  assign entry_hit   = scan_vld
                       && (entry_addr[ADDR_W-1:PAGE_OFS_W] == commit_page)
                       && ({1'b0, entry_addr} < MEM_LIMIT);
  assign tick_count  = countdown - DELAY_W'(1);

  // Storage read happens only for an accepted read; buffer append only for a
  // write in page mode while there is room.
  assign mem_re = accept && (action == ACT_READ);
  assign buf_we = accept && (action == ACT_WRITE) && (seq_state == SQ_PAGE)
                  && (pending_count < BUF_FULL);
  assign buf_re = scan_issue;

  // Storage write port: erase sweep, page fill with FF, then buffered bytes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = erase_idx;
    mem_wdata = ERASED_BYTE;
    unique case (state)
      ST_ERASE: begin
        mem_we = 1'b1;
      end
      ST_FILL: begin
        mem_we    = ({1'b0, fill_addr} < MEM_LIMIT);
        mem_waddr = fill_addr[AW-1:0];
      end
      ST_SCAN: begin
        mem_we    = entry_hit;
        mem_waddr = entry_addr[AW-1:0];
        mem_wdata = buf_q[DATA_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  pecpw_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MEMORY_BYTES)
  ) u_storage (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(address[AW-1:0]),
    .rdata(mem_q)
  );

  pecpw_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BUFFER_ENTRIES)
  ) u_pending (
    .clk  (clk),
    .we   (buf_we),
    .waddr(pending_count[BW-1:0]),
    .wdata({address, data}),
    .re   (buf_re),
    .raddr(scan_idx[BW-1:0]),
    .rdata(buf_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      product_id        <= '0;
      write_delay_ticks <= DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRODUCT_ID:  product_id        <= cfg_data;
        CFG_WRITE_DELAY: write_delay_ticks <= cfg_data;
        default:         product_id        <= product_id;
      endcase
    end
  end

  // Main controller: decodes each item and runs the memory walks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      seq_state          <= SQ_START;
      id_mode            <= 1'b0;
      countdown          <= '0;
      pending_count      <= '0;
      last_write_address <= '0;
      done               <= 1'b0;
      write_busy         <= 1'b0;
      rd_from_ram        <= 1'b0;
      rd_reg             <= '0;
      erase_idx          <= '0;
      fill_idx           <= '0;
      scan_idx           <= '0;
      scan_vld           <= 1'b0;
    end else begin
      done     <= 1'b0;
      scan_vld <= scan_issue;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            done        <= 1'b1;
            rd_from_ram <= 1'b0;
            rd_reg      <= '0;
            write_busy  <= (countdown != '0);
            unique case (action)
              ACT_READ: begin
                if (id_mode) begin
                  if (address == addr_t'(0)) begin
                    rd_reg <= product_id[ID_W-1:DATA_W];
                  end else if (address == addr_t'(1)) begin
                    rd_reg <= product_id[DATA_W-1:0];
                  end
                end else if ({1'b0, address} < MEM_LIMIT) begin
                  rd_from_ram <= 1'b1;
                end
              end
              ACT_WRITE: begin
                unique case (seq_state)
                  SQ_START, SQ_START2: begin
                    if (address == UNLOCK_ADDR1 && data == UNLOCK_BYTE1) begin
                      seq_state <= (seq_state == SQ_START) ? SQ_GOT_AA : SQ_GOT_AA2;
                    end
                  end
                  SQ_GOT_AA, SQ_GOT_AA2: begin
                    if (address == UNLOCK_ADDR2 && data == UNLOCK_BYTE2) begin
                      seq_state <= (seq_state == SQ_GOT_AA) ? SQ_COMMAND : SQ_COMMAND2;
                    end
                  end
                  SQ_COMMAND: begin
                    if (address == UNLOCK_ADDR1) begin
                      if (data == CMD_PAGE_WRITE) begin
                        seq_state     <= SQ_PAGE;
                        pending_count <= '0;
                        countdown     <= write_delay_ticks;
                        write_busy    <= (write_delay_ticks != '0);
                      end else if (data == CMD_SECOND_SEQ) begin
                        seq_state <= SQ_START2;
                      end else if (data == CMD_ID_MODE) begin
                        seq_state <= SQ_START;
                        id_mode   <= 1'b1;
                      end else if (data == CMD_NORMAL) begin
                        seq_state <= SQ_START;
                        id_mode   <= 1'b0;
                      end
                    end
                  end
                  SQ_PAGE: begin
                    if (pending_count < BUF_FULL) begin
                      pending_count      <= pending_count + CW'(1);
                      last_write_address <= address;
                    end
                    countdown  <= write_delay_ticks;
                    write_busy <= (write_delay_ticks != '0);
                  end
                  SQ_COMMAND2: begin
                    if (address == UNLOCK_ADDR1) begin
                      if (data == CMD_PROT_OFF) begin
                        seq_state <= SQ_START;
                      end else if (data == CMD_ERASE) begin
                        seq_state <= SQ_START;
                        erase_idx <= '0;
                        state     <= ST_ERASE;
                      end else if (data == CMD_ID_MODE2) begin
                        seq_state <= SQ_START;
                        id_mode   <= 1'b1;
                      end
                    end
                  end
                  default: begin
                    seq_state <= seq_state;
                  end
                endcase
              end
              ACT_TICK: begin
                if (countdown != '0) begin
                  countdown  <= tick_count;
                  write_busy <= (tick_count != '0);
                  if (tick_count == '0) begin
                    // Countdown expired: rewrite the page of the last address.
                    seq_state <= SQ_START;
                    fill_idx  <= '0;
                    state     <= ST_FILL;
                  end
                end
              end
              default: begin
                rd_reg <= '0;
              end
            endcase
          end
        end
        ST_ERASE: begin
          erase_idx <= erase_idx + AW'(1);
          if (erase_idx == ERASE_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_FILL: begin
          fill_idx <= fill_idx + PAGE_OFS_W'(1);
          if (fill_idx == PAGE_OFS_W'(PAGE_BYTES - 1)) begin
            scan_idx <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Entries are replayed in arrival order so later bytes win.
          if (scan_issue) begin
            scan_idx <= scan_idx + CW'(1);
          end else if (!scan_vld) begin
            pending_count <= '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pecpw_checker.sv =====
// Port-level checker for the page-write EEPROM block, bound to its top level.
`include "assert_macros.svh"

module pecpw_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input pecpw_pkg::action_t action,
  input logic               done,
  input logic               write_busy
);

  import pecpw_pkg::*;

  logic accept;
  logic long_cause;

  assign accept     = start && !busy;
  assign long_cause = (action == ACT_WRITE) || (action == ACT_TICK);

  `ASSERT_NEXT(a_result_follows, clk, rst, accept, done, "item gave no result")
  `ASSERT_SAME(a_no_spurious, clk, rst, done, $past(accept), "result without item")
  `ASSERT_SAME(a_busy_cause, clk, rst, $rose(busy), $past(accept) && $past(long_cause), "busy without write or tick")
  `ASSERT_SAME(a_commit_idle, clk, rst, $rose(busy) && $past(action) == ACT_TICK, !write_busy, "commit left countdown running")

endmodule

bind parallel_eeprom_command_page_write pecpw_checker u_pecpw_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .action    (action),
  .done      (done),
  .write_busy(write_busy)
);
